// ----- rtl/matrix_keypad_scanner_top_defines.svh -----
// Assertion macros used by the RTL of the keypad scanner.
`ifndef MATRIX_KEYPAD_SCANNER_TOP_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_TOP_DEFINES_SVH

// Overlapping implication: the consequent must hold in the same cycle.
`define MKS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Non-overlapping implication: the consequent must hold in the next cycle.
`define MKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ----- rtl/mks_pkg.sv -----
package mks_pkg;

	localparam int unsigned COL_W     = 4;
	localparam int unsigned ROW_W     = 4;
	localparam int unsigned KEY_W     = 8;
	localparam int unsigned TIMER_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;
	localparam int unsigned NUM_ROWS  = 4;

	localparam logic [COL_W-1:0] COLS_IDLE = 4'h0F;
	localparam logic [COL_W-1:0] COL0_LOW  = 4'h0E;
	localparam logic [COL_W-1:0] COL1_LOW  = 4'h0D;
	localparam logic [COL_W-1:0] COL2_LOW  = 4'h0B;
	localparam logic [COL_W-1:0] COL3_LOW  = 4'h07;

	localparam logic [TIMER_W-1:0]   DEBOUNCE_RESET = 16'd20;
	localparam logic [KEY_W-1:0]     LAST_KEY_RESET = 8'd110;
	localparam logic [CFG_DAT_W-1:0] KEYMAP_ROW0_RESET = 32'd724775473;
	localparam logic [CFG_DAT_W-1:0] KEYMAP_ROW1_RESET = 32'd758527284;
	localparam logic [CFG_DAT_W-1:0] KEYMAP_ROW2_RESET = 32'd708393015;
	localparam logic [CFG_DAT_W-1:0] KEYMAP_ROW3_RESET = 32'd792539235;

	typedef enum logic [1:0] {
		PH_PRESS,
		PH_CONFIRM,
		PH_SCAN,
		PH_RELEASE
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE    = 3'd0,
		REG_KEYMAP_ROW0 = 3'd1,
		REG_KEYMAP_ROW1 = 3'd2,
		REG_KEYMAP_ROW2 = 3'd3,
		REG_KEYMAP_ROW3 = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] col;
	} col_hit_t;

	// Maps a one-hot-low column code to its column number.
	function automatic col_hit_t col_decode(input logic [COL_W-1:0] levels);
		col_hit_t res;
		res = '{hit: 1'b1, col: 2'd0};
		unique case (levels)
			COL0_LOW: res.col = 2'd0;
			COL1_LOW: res.col = 2'd1;
			COL2_LOW: res.col = 2'd2;
			COL3_LOW: res.col = 2'd3;
			default:  res.hit = 1'b0;
		endcase
		return res;
	endfunction

endpackage

// ----- rtl/mks_col_if.sv -----
interface mks_col_if;
	logic                      valid;
	logic                      ready;
	logic [mks_pkg::COL_W-1:0] col_levels;

	modport source (output valid, output col_levels, input ready);
	modport sink   (input valid, input col_levels, output ready);
endinterface

// ----- rtl/mks_key_if.sv -----
interface mks_key_if;
	logic                      valid;
	logic                      ready;
	logic [mks_pkg::ROW_W-1:0] row_drive;
	logic                      key_valid;
	logic [mks_pkg::KEY_W-1:0] key_code;

	modport source (output valid, output row_drive, output key_valid, output key_code,
		input ready);
	modport sink   (input valid, input row_drive, input key_valid, input key_code,
		output ready);
endinterface

// ----- rtl/mks_cfg_if.sv -----
interface mks_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mks_pkg::CFG_IDX_W-1:0] index;
	logic [mks_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/matrix_keypad_scanner_top.sv -----
// Tick-driven scanner for a 4x4 key matrix. Every request on col_in is one tick
// and carries the active-low column levels seen under the row drive of the
// previous result; every tick gives exactly one result on key_out with the row
// drive for the next tick, a key_valid flag when a released key is reported,
// and the last decoded key code. The block takes one tick per clock cycle when
// not stalled: the state update and the result are formed combinationally and
// held in a single output register, which is refilled in the same cycle that
// the consumer takes it, so a stall on key_out holds col_in only while the
// result register is full and not being drained. Configuration registers
// (debounce count, and the four key-table rows) are written through cfg and
// always accepted; they should only be changed while no tick is in flight.

`include "matrix_keypad_scanner_top_defines.svh"

module matrix_keypad_scanner_top (
	input logic           clk,
	input logic           arst_n,
	mks_cfg_if.sink       cfg,
	mks_col_if.sink       col_in,
	mks_key_if.source     key_out
);

	// Configuration registers.
	logic [mks_pkg::TIMER_W-1:0]   debounce_q;
	logic [mks_pkg::CFG_DAT_W-1:0] keymap_q [mks_pkg::NUM_ROWS];

	// Scanner state.
	mks_pkg::phase_t             phase_q, phase_d;
	logic [mks_pkg::TIMER_W-1:0] timer_q, timer_d;
	logic [1:0]                  scan_row_q, scan_row_d;
	logic [mks_pkg::KEY_W-1:0]   last_key_q, last_key_d;

	// Result register.
	logic                      out_valid_q;
	logic [mks_pkg::ROW_W-1:0] row_drive_q, row_drive_d;
	logic                      key_valid_q, key_valid_d;
	logic [mks_pkg::KEY_W-1:0] key_code_q;

	logic                        accept;
	logic [mks_pkg::TIMER_W-1:0] limit;
	logic [mks_pkg::TIMER_W:0]   timer_inc;
	logic                        sample_due;
	logic                        cols_idle;
	mks_pkg::col_hit_t           hit;
	logic [mks_pkg::CFG_DAT_W-1:0] row_codes;

	assign cfg.ready = 1'b1;

	// A new tick can enter whenever the result register is empty or is being
	// drained in this cycle.
	assign col_in.ready = !out_valid_q || key_out.ready;
	assign accept       = col_in.valid && col_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= mks_pkg::DEBOUNCE_RESET;
			keymap_q[0] <= mks_pkg::KEYMAP_ROW0_RESET;
			keymap_q[1] <= mks_pkg::KEYMAP_ROW1_RESET;
			keymap_q[2] <= mks_pkg::KEYMAP_ROW2_RESET;
			keymap_q[3] <= mks_pkg::KEYMAP_ROW3_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mks_pkg::REG_DEBOUNCE:    debounce_q  <= cfg.data[mks_pkg::TIMER_W-1:0];
				mks_pkg::REG_KEYMAP_ROW0: keymap_q[0] <= cfg.data;
				mks_pkg::REG_KEYMAP_ROW1: keymap_q[1] <= cfg.data;
				mks_pkg::REG_KEYMAP_ROW2: keymap_q[2] <= cfg.data;
				mks_pkg::REG_KEYMAP_ROW3: keymap_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// A debounce count of zero samples on every tick, the same as one.
	assign limit      = (debounce_q == '0) ? mks_pkg::TIMER_W'(1) : debounce_q;
	assign timer_inc  = {1'b0, timer_q} + (mks_pkg::TIMER_W+1)'(1);
	assign sample_due = timer_inc >= {1'b0, limit};
	assign cols_idle  = col_in.col_levels == mks_pkg::COLS_IDLE;
	assign hit        = mks_pkg::col_decode(col_in.col_levels);
	assign row_codes  = keymap_q[scan_row_q];

	// Next-state logic for one tick.
	always_comb begin
		phase_d    = phase_q;
		timer_d    = timer_q;
		scan_row_d = scan_row_q;
		last_key_d = last_key_q;
		unique case (phase_q)
			mks_pkg::PH_PRESS: begin
				timer_d = sample_due ? '0 : timer_inc[mks_pkg::TIMER_W-1:0];
				if (sample_due && !cols_idle) begin
					phase_d = mks_pkg::PH_CONFIRM;
				end
			end
			mks_pkg::PH_CONFIRM: begin
				timer_d = sample_due ? '0 : timer_inc[mks_pkg::TIMER_W-1:0];
				if (sample_due) begin
					if (cols_idle) begin
						// The confirm sample was clear: treat it as a bounce.
						phase_d = mks_pkg::PH_PRESS;
					end else begin
						phase_d    = mks_pkg::PH_SCAN;
						scan_row_d = 2'd0;
					end
				end
			end
			mks_pkg::PH_SCAN: begin
				if (!cols_idle) begin
					// Several columns low at once keeps the previous key.
					if (hit.hit) begin
						last_key_d = row_codes[{hit.col, 3'b000} +: mks_pkg::KEY_W];
					end
					phase_d = mks_pkg::PH_RELEASE;
				end else begin
					scan_row_d = scan_row_q + 2'd1;
				end
			end
			mks_pkg::PH_RELEASE: begin
				if (cols_idle) begin
					phase_d = mks_pkg::PH_PRESS;
					timer_d = '0;
				end
			end
			default: phase_d = mks_pkg::PH_PRESS;
		endcase
	end

	// Result of the tick: only the scanned row is grounded while scanning.
	always_comb begin
		row_drive_d = '0;
		key_valid_d = 1'b0;
		if (phase_d == mks_pkg::PH_SCAN) begin
			row_drive_d = ~(mks_pkg::ROW_W'(1) << scan_row_d);
		end
		if (phase_q == mks_pkg::PH_RELEASE && cols_idle) begin
			key_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mks_pkg::PH_PRESS;
			timer_q     <= '0;
			scan_row_q  <= 2'd0;
			last_key_q  <= mks_pkg::LAST_KEY_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				timer_q     <= timer_d;
				scan_row_q  <= scan_row_d;
				last_key_q  <= last_key_d;
				out_valid_q <= 1'b1;
			end else if (key_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_drive_q <= row_drive_d;
			key_valid_q <= key_valid_d;
			key_code_q  <= last_key_d;
		end
	end

	assign key_out.valid     = out_valid_q;
	assign key_out.row_drive = row_drive_q;
	assign key_out.key_valid = key_valid_q;
	assign key_out.key_code  = key_code_q;

	// A reported key always comes with all rows grounded.
	`MKS_ASSERT_SAME(a_report_all_rows, clk, arst_n,
		out_valid_q && key_valid_q, row_drive_q == '0)

	// While scanning, exactly one row is grounded.
	`MKS_ASSERT_SAME(a_single_row, clk, arst_n,
		out_valid_q && row_drive_q != '0, $onehot(~row_drive_q))

	// An idle tick during the scan moves on to the next row.
	`MKS_ASSERT_NEXT(a_row_advance, clk, arst_n,
		accept && phase_q == mks_pkg::PH_SCAN && cols_idle,
		scan_row_q == 2'($past(scan_row_q) + 2'd1))

	// A key is only reported by a tick taken in the release phase.
	`MKS_ASSERT_NEXT(a_report_from_release, clk, arst_n,
		accept && phase_q != mks_pkg::PH_RELEASE, !key_valid_q)

endmodule
